@@ src/imuf_pkg.sv @@
// Shared types and constants for the up-vector complementary filter.
package imuf_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_FILTER_RATE = 2'd0;
	localparam logic [1:0] CFG_WINDOW_LOW  = 2'd1;
	localparam logic [1:0] CFG_WINDOW_HIGH = 2'd2;

	localparam logic [23:0] FILTER_RATE_RESET = 24'd81920;
	localparam logic [30:0] WINDOW_LOW_RESET  = 31'd524288;
	localparam logic [30:0] WINDOW_HIGH_RESET = 31'd786432;

	// Square root runs one result bit per cycle over a 64-bit radicand
	localparam int unsigned SQRT_STEPS = 32;

	typedef enum logic [4:0] {
		OP_YAW_X, OP_YAW_Y, OP_YAW_Z, OP_YAW_DT,
		OP_CX_A, OP_CX_B, OP_WX_DT,
		OP_CY_A, OP_CY_B, OP_WY_DT,
		OP_CZ_A, OP_CZ_B, OP_WZ_DT,
		OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_LO2, OP_HI2,
		OP_CE_X, OP_CD_X, OP_CE_Y, OP_CD_Y, OP_CE_Z, OP_CD_Z,
		OP_M_X, OP_M_Y, OP_M_Z,
		OP_G_X, OP_G_Y, OP_G_Z
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_WINDOW, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_GAIN, ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] gyro_x;
		logic [31:0] gyro_y;
		logic [31:0] gyro_z;
		logic [31:0] accel_x;
		logic [31:0] accel_y;
		logic [31:0] accel_z;
		logic [23:0] time_step;
	} item_t;

	typedef struct packed {
		logic [31:0] up_x_out;
		logic [31:0] up_y_out;
		logic [31:0] up_z_out;
		logic [31:0] yaw_angle_out;
		logic        accel_used;
	} result_t;

	typedef struct packed {
		logic [23:0] filter_rate;
		logic [30:0] accel_window_low;
		logic [30:0] accel_window_high;
	} cfg_t;

	typedef struct packed {
		op_t  op;
		logic start;
		logic load;
		logic mlo;
		logic mhi;
		logic wb;
		logic win;
		logic sq_init;
		logic sq_step;
		logic div_init;
		logic div_step;
		logic gain;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic used;
		logic unit;
	} stat_t;

endpackage

@@ src/imuf_ctrl.sv @@
// Sequencer for the filter datapath: multiply micro-ops, square root and divides.
module imuf_ctrl #(
	parameter int unsigned UP_FRACTION_BITS = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  imuf_pkg::stat_t stat,
	output imuf_pkg::cmd_t  cmd
);
	import imuf_pkg::*;

	localparam logic [4:0] DIV_LAST  = 5'(UP_FRACTION_BITS);
	localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);

	state_t     state_q, state_d;
	op_t        op_q, op_d;
	logic [1:0] phase_q, phase_d;
	logic [4:0] cnt_q, cnt_d;
	logic       valid_q, valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_YAW_X;
			phase_q <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			valid_q <= valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		valid_d = valid_q && !out_ready;
		cmd     = '0;
		cmd.op  = op_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					op_d      = OP_YAW_X;
					phase_d   = '0;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				phase_d = phase_q + 2'd1;
				case (phase_q)
					2'd0: cmd.load = 1'b1;
					2'd1: cmd.mlo  = 1'b1;
					2'd2: cmd.mhi  = 1'b1;
					default: begin
						cmd.wb = 1'b1;
						case (op_q)
							OP_HI2: state_d = ST_WINDOW;
							OP_CD_X, OP_CD_Y: begin
								op_d    = op_t'(op_q + 5'd1);
								state_d = ST_DIV_INIT;
							end
							OP_M_Z: state_d = ST_GAIN;
							OP_G_Z: state_d = ST_FINISH;
							default: op_d = op_t'(op_q + 5'd1);
						endcase
					end
				endcase
			end
			ST_WINDOW: begin
				cmd.win = 1'b1;
				phase_d = '0;
				cnt_d   = '0;
				if (stat.used) begin
					cmd.sq_init = 1'b1;
					op_d        = OP_CE_X;
					state_d     = ST_SQRT;
				end else begin
					op_d    = OP_M_X;
					state_d = ST_MUL;
				end
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_q + 5'd1;
				if (cnt_q == SQRT_LAST) begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) begin
					phase_d = '0;
					state_d = ST_MUL;
				end
			end
			ST_GAIN: begin
				phase_d = '0;
				if (stat.unit) begin
					state_d = ST_FINISH;
				end else begin
					cmd.gain = 1'b1;
					op_d     = OP_G_X;
					state_d  = ST_MUL;
				end
			end
			ST_FINISH: begin
				// hold while the previous result still sits unclaimed
				if (!(valid_q && !out_ready)) begin
					cmd.commit = 1'b1;
					valid_d    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = valid_q;

endmodule

@@ src/imuf_datapath.sv @@
// Filter datapath: shared two-step multiplier, square root, divider and state.
module imuf_datapath #(
	parameter int unsigned UP_FRACTION_BITS = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  imuf_pkg::cmd_t    cmd,
	input  imuf_pkg::item_t   item,
	input  imuf_pkg::cfg_t    cfg,
	output imuf_pkg::stat_t   stat,
	output imuf_pkg::result_t result
);
	import imuf_pkg::*;

	localparam int unsigned F = UP_FRACTION_BITS;
	localparam logic [31:0] UP_ONE    = 32'(64'd1 << F);
	localparam logic [63:0] UNIT_NORM = 64'd1 << (2 * F);
	localparam logic [31:0] GAIN_MIN  = 32'(((64'd1 << F) + 64'd50) / 64'd100);
	localparam logic [31:0] GAIN_BASE = 32'(64'd3 << (F - 1));

	logic signed [31:0] g_q [3];
	logic signed [31:0] a_q [3];
	logic        [23:0] dt_q;
	logic signed [31:0] u_q [3];
	logic signed [31:0] un_q [3];
	logic signed [31:0] yaw_q;
	logic signed [63:0] rate_q;
	logic signed [63:0] w_q;
	logic signed [63:0] t_q;
	logic        [63:0] s_q, lo2_q, hi2_q, m_q;
	logic        [63:0] sq_rem_q, sq_res_q, sq_bit_q;
	logic        [32:0] dv_rem_q;
	logic               dv_bit_q;
	logic        [31:0] dv_quo_q;
	logic        [31:0] gain_q;
	logic               used_q;
	logic signed [63:0] pa_q;
	logic signed [32:0] pb_q;
	logic signed [96:0] p_q;
	result_t            res_q;

	logic        [1:0]  ax;
	logic signed [63:0] op_a;
	logic signed [32:0] op_b;
	logic signed [63:0] p64;
	logic signed [31:0] n_val;
	logic signed [32:0] e_val;
	logic        [31:0] mag;
	logic        [63:0] sq_try;
	logic        [33:0] dv_try;
	logic signed [64:0] gain_raw;

	always_comb begin
		case (cmd.op)
			OP_YAW_X, OP_SQ_X, OP_CE_X, OP_CD_X, OP_M_X, OP_G_X: ax = 2'd0;
			OP_YAW_Y, OP_SQ_Y, OP_CE_Y, OP_CD_Y, OP_M_Y, OP_G_Y: ax = 2'd1;
			OP_YAW_Z, OP_SQ_Z, OP_CE_Z, OP_CD_Z, OP_M_Z, OP_G_Z: ax = 2'd2;
			default: ax = 2'd0;
		endcase
	end

	assign mag    = a_q[ax][31] ? 32'(-a_q[ax]) : a_q[ax];
	assign n_val  = a_q[ax][31] ? -$signed(dv_quo_q) : $signed(dv_quo_q);
	assign e_val  = 33'(n_val) - 33'(un_q[ax]);
	assign p64    = p_q[63:0];
	assign sq_try = sq_res_q + sq_bit_q;
	assign dv_try = {dv_rem_q, dv_bit_q};

	always_comb begin
		op_a = 64'(u_q[ax]);
		op_b = 33'(g_q[ax]);
		case (cmd.op)
			OP_YAW_X, OP_YAW_Y, OP_YAW_Z: begin
				op_a = 64'(u_q[ax]);
				op_b = 33'(g_q[ax]);
			end
			OP_YAW_DT: begin
				op_a = rate_q;
				op_b = {9'd0, dt_q};
			end
			OP_CX_A: begin op_a = 64'(g_q[2]); op_b = 33'(u_q[1]); end
			OP_CX_B: begin op_a = 64'(g_q[1]); op_b = 33'(u_q[2]); end
			OP_CY_A: begin op_a = 64'(g_q[0]); op_b = 33'(u_q[2]); end
			OP_CY_B: begin op_a = 64'(g_q[2]); op_b = 33'(u_q[0]); end
			OP_CZ_A: begin op_a = 64'(g_q[1]); op_b = 33'(u_q[0]); end
			OP_CZ_B: begin op_a = 64'(g_q[0]); op_b = 33'(u_q[1]); end
			OP_WX_DT, OP_WY_DT, OP_WZ_DT: begin
				op_a = w_q;
				op_b = {9'd0, dt_q};
			end
			OP_SQ_X, OP_SQ_Y, OP_SQ_Z: begin
				op_a = 64'(a_q[ax]);
				op_b = 33'(a_q[ax]);
			end
			OP_LO2: begin
				op_a = {33'd0, cfg.accel_window_low};
				op_b = {2'd0, cfg.accel_window_low};
			end
			OP_HI2: begin
				op_a = {33'd0, cfg.accel_window_high};
				op_b = {2'd0, cfg.accel_window_high};
			end
			OP_CE_X, OP_CE_Y, OP_CE_Z: begin
				op_a = 64'(e_val);
				op_b = {9'd0, cfg.filter_rate};
			end
			OP_CD_X, OP_CD_Y, OP_CD_Z: begin
				op_a = t_q;
				op_b = {9'd0, dt_q};
			end
			OP_M_X, OP_M_Y, OP_M_Z: begin
				op_a = 64'(un_q[ax]);
				op_b = 33'(un_q[ax]);
			end
			OP_G_X, OP_G_Y, OP_G_Z: begin
				op_a = 64'(un_q[ax]);
				op_b = {1'b0, gain_q};
			end
			default: ;
		endcase
	end

	assign gain_raw = 65'(GAIN_BASE) - $signed({1'b0, m_q >> (F + 1)});

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q[0] <= '0;
			u_q[1] <= '0;
			u_q[2] <= UP_ONE;
			yaw_q  <= '0;
			used_q <= 1'b0;
		end else begin
			if (cmd.wb && cmd.op == OP_YAW_DT) begin
				yaw_q <= yaw_q + p_q[55:24];
			end
			if (cmd.win) begin
				used_q <= stat.used;
			end
			if (cmd.commit) begin
				u_q[0] <= un_q[0];
				u_q[1] <= un_q[1];
				u_q[2] <= un_q[2];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			g_q[0] <= item.gyro_x;
			g_q[1] <= item.gyro_y;
			g_q[2] <= item.gyro_z;
			a_q[0] <= item.accel_x;
			a_q[1] <= item.accel_y;
			a_q[2] <= item.accel_z;
			dt_q   <= item.time_step;
		end
		if (cmd.load) begin
			pa_q <= op_a;
			pb_q <= op_b;
		end
		if (cmd.mlo) begin
			p_q <= 97'(pa_q * $signed({1'b0, pb_q[15:0]}));
		end
		if (cmd.mhi) begin
			p_q <= p_q + (97'(pa_q * $signed(pb_q[32:16])) <<< 16);
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_YAW_X: rate_q <= p64 >>> F;
				OP_YAW_Y, OP_YAW_Z: rate_q <= rate_q + (p64 >>> F);
				OP_CX_A, OP_CY_A, OP_CZ_A: w_q <= p64 >>> 16;
				OP_CX_B, OP_CY_B, OP_CZ_B: w_q <= w_q - (p64 >>> 16);
				OP_WX_DT: un_q[0] <= u_q[0] + p_q[55:24];
				OP_WY_DT: un_q[1] <= u_q[1] + p_q[55:24];
				OP_WZ_DT: un_q[2] <= u_q[2] + p_q[55:24];
				OP_SQ_X: s_q <= p_q[63:0];
				OP_SQ_Y, OP_SQ_Z: s_q <= s_q + p_q[63:0];
				OP_LO2: lo2_q <= p_q[63:0];
				OP_HI2: hi2_q <= p_q[63:0];
				OP_CE_X, OP_CE_Y, OP_CE_Z: t_q <= p64;
				OP_CD_X, OP_CD_Y, OP_CD_Z: un_q[ax] <= un_q[ax] + p_q[71:40];
				OP_M_X: m_q <= p_q[63:0];
				OP_M_Y, OP_M_Z: m_q <= m_q + p_q[63:0];
				OP_G_X, OP_G_Y, OP_G_Z: un_q[ax] <= p_q[F + 31:F];
				default: ;
			endcase
		end
		if (cmd.sq_init) begin
			sq_rem_q <= s_q;
			sq_res_q <= '0;
			sq_bit_q <= 64'd1 << 62;
		end
		if (cmd.sq_step) begin
			if (sq_rem_q >= sq_try) begin
				sq_rem_q <= sq_rem_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		// quotient of (mag << F) / norm, one bit per step
		if (cmd.div_init) begin
			dv_rem_q <= {2'd0, mag[31:1]};
			dv_bit_q <= mag[0];
			dv_quo_q <= '0;
		end
		if (cmd.div_step) begin
			dv_bit_q <= 1'b0;
			if (dv_try >= {1'b0, sq_res_q[32:0]}) begin
				dv_rem_q <= 33'(dv_try - {1'b0, sq_res_q[32:0]});
				dv_quo_q <= {dv_quo_q[30:0], 1'b1};
			end else begin
				dv_rem_q <= dv_try[32:0];
				dv_quo_q <= {dv_quo_q[30:0], 1'b0};
			end
		end
		if (cmd.gain) begin
			gain_q <= (gain_raw < $signed(65'(GAIN_MIN))) ? GAIN_MIN : gain_raw[31:0];
		end
		if (cmd.commit) begin
			res_q.up_x_out      <= un_q[0];
			res_q.up_y_out      <= un_q[1];
			res_q.up_z_out      <= un_q[2];
			res_q.yaw_angle_out <= yaw_q;
			res_q.accel_used    <= used_q;
		end
	end

	assign stat.used = (s_q > lo2_q) && (s_q < hi2_q);
	assign stat.unit = (m_q == UNIT_NORM);
	assign result    = res_q;

endmodule

@@ src/imu_up_vector_complementary_filter.sv @@
// Top level of the up-vector complementary filter with yaw integration.
//
// Input stream (s_*): one transaction per IMU sample carrying gyro, accel and
// time step. Output stream (m_*): one transaction per sample with the updated
// up vector (Q2.F), the wrapped yaw angle (Q16.16) and the correction flag.
// Configuration channel (cfg_*): writes filter_rate (0), accel_window_low (1)
// and accel_window_high (2); always ready, write only while idle.
//
// One sample at a time. The shared multiplier is used for 24 products per
// sample (21 when the vector is already unit length). With correction add a
// square root, three divides and six products.
// s_tready is high only while no sample is in flight.
//
// Reset sets the up vector to (0, 0, 1), the yaw to zero and the registers to
// their defaults. A finished result waits in the output register; the next
// sample is accepted meanwhile, and completes only once m_tready takes the
// held result.
module imu_up_vector_complementary_filter #(
	parameter int unsigned UP_FRACTION_BITS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, time_step
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// up_x_out, up_y_out, up_z_out, yaw_angle_out
	output logic [127:0] m_tdata,
	// accel_used
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);
	import imuf_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	result_t result;
	cmd_t    cmd;
	stat_t   stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_rate       <= FILTER_RATE_RESET;
			cfg_q.accel_window_low  <= WINDOW_LOW_RESET;
			cfg_q.accel_window_high <= WINDOW_HIGH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FILTER_RATE: cfg_q.filter_rate       <= cfg_data[23:0];
				CFG_WINDOW_LOW:  cfg_q.accel_window_low  <= cfg_data;
				CFG_WINDOW_HIGH: cfg_q.accel_window_high <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	assign item.gyro_x    = s_tdata[31:0];
	assign item.gyro_y    = s_tdata[63:32];
	assign item.gyro_z    = s_tdata[95:64];
	assign item.accel_x   = s_tdata[127:96];
	assign item.accel_y   = s_tdata[159:128];
	assign item.accel_z   = s_tdata[191:160];
	assign item.time_step = s_tdata[215:192];

	imuf_ctrl #(
		.UP_FRACTION_BITS(UP_FRACTION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	imuf_datapath #(
		.UP_FRACTION_BITS(UP_FRACTION_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.item  (item),
		.cfg   (cfg_q),
		.stat  (stat),
		.result(result)
	);

	assign m_tdata = {result.yaw_angle_out, result.up_z_out, result.up_y_out, result.up_x_out};
	assign m_tuser = result.accel_used;

endmodule

@@ verif/imuf_checker.sv @@
// Checker for the up-vector filter: predicts each result and compares it.
module imuf_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [215:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data,
	output int           error_count,
	output int           pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import imuf_pkg::*;

	localparam int FB = 30;

	typedef struct {
		logic [31:0] ux, uy, uz, yaw;
		logic        used;
	} filt_out_t;

	logic [23:0] rate_q;
	logic [30:0] win_lo, win_hi;
	logic signed [31:0] st_up [3];
	logic signed [31:0] st_yaw;
	filt_out_t expected_q[$];

	function automatic logic signed [63:0] scale_dt(input logic signed [63:0] a,
			input logic [23:0] d);
		logic signed [63:0] hi, lo;
		hi = a >>> 24;
		lo = a - (hi <<< 24);
		return hi * $signed({40'd0, d}) + ((lo * $signed({40'd0, d})) >>> 24);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic advance_filter(input logic [215:0] d);
		logic signed [63:0] g [3], a [3], u [3], w [3];
		logic signed [63:0] spin, q, n, c, gain;
		logic [63:0] s, lo2, hi2, m, nrm, mag;
		logic [23:0] dt;
		logic used;
		filt_out_t r;
		for (int i = 0; i < 3; i++) begin
			g[i] = $signed(d[32*i +: 32]);
			a[i] = $signed(d[96 + 32*i +: 32]);
			u[i] = st_up[i];
		end
		dt = d[215:192];
		spin = 0;
		for (int i = 0; i < 3; i++) spin += (u[i] * g[i]) >>> FB;
		st_yaw = st_yaw + 32'(scale_dt(spin, dt));
		w[0] = ((g[2] * u[1]) >>> 16) - ((g[1] * u[2]) >>> 16);
		w[1] = ((g[0] * u[2]) >>> 16) - ((g[2] * u[0]) >>> 16);
		w[2] = ((g[1] * u[0]) >>> 16) - ((g[0] * u[1]) >>> 16);
		for (int i = 0; i < 3; i++)
			u[i] = $signed(32'(u[i] + scale_dt(w[i], dt)));
		s = 0;
		for (int i = 0; i < 3; i++) s += a[i] * a[i];
		lo2 = {33'd0, win_lo} * {33'd0, win_lo};
		hi2 = {33'd0, win_hi} * {33'd0, win_hi};
		used = (s > lo2) && (s < hi2);
		if (used) begin
			nrm = int_sqrt(s);
			for (int i = 0; i < 3; i++) begin
				mag = a[i] < 0 ? -a[i] : a[i];
				q = $signed((mag << FB) / nrm);
				n = a[i] < 0 ? -q : q;
				c = scale_dt((n - u[i]) * $signed({40'd0, rate_q}), dt) >>> 16;
				u[i] = $signed(32'(u[i] + c));
			end
		end
		m = 0;
		for (int i = 0; i < 3; i++) m += u[i] * u[i];
		if (m != 64'd1 << (2*FB)) begin
			gain = (64'sd3 <<< (FB-1)) - $signed(m >> (FB+1));
			if (gain < ((64'sd1 <<< FB) + 50) / 100) gain = ((64'sd1 <<< FB) + 50) / 100;
			for (int i = 0; i < 3; i++) u[i] = $signed(32'((u[i] * gain) >>> FB));
		end
		for (int i = 0; i < 3; i++) st_up[i] = u[i][31:0];
		r.ux = st_up[0];
		r.uy = st_up[1];
		r.uz = st_up[2];
		r.yaw = st_yaw;
		r.used = used;
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		filt_out_t e;
		if (!arst_n) begin
			rate_q <= FILTER_RATE_RESET;
			win_lo <= WINDOW_LOW_RESET;
			win_hi <= WINDOW_HIGH_RESET;
			st_up[0] = 0;
			st_up[1] = 0;
			st_up[2] = 32'sd1 <<< FB;
			st_yaw = 0;
			expected_q.delete();
			error_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FILTER_RATE: rate_q <= cfg_data[23:0];
					CFG_WINDOW_LOW: win_lo <= cfg_data;
					CFG_WINDOW_HIGH: win_hi <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$display("%0t ns: result with nothing expected", $realtime);
					error_count++;
				end else begin
					e = expected_q.pop_front();
					if (m_tdata[31:0] !== e.ux) report_mismatch("up_x", m_tdata[31:0], e.ux);
					if (m_tdata[63:32] !== e.uy) report_mismatch("up_y", m_tdata[63:32], e.uy);
					if (m_tdata[95:64] !== e.uz) report_mismatch("up_z", m_tdata[95:64], e.uz);
					if (m_tdata[127:96] !== e.yaw)
						report_mismatch("yaw", m_tdata[127:96], e.yaw);
					if (m_tuser[0] !== e.used)
						report_mismatch("accel_used", {31'd0, m_tuser}, {31'd0, e.used});
				end
			end
			if (s_tvalid && s_tready) advance_filter(s_tdata);
		end
	end

	assign pending_count = expected_q.size();
endmodule

@@ verif/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the up-vector filter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import imuf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid, s_tready;
	logic [215:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid, cfg_ready;
	logic [1:0]   cfg_index;
	logic [30:0]  cfg_data;
	int           error_count, pending_count;
	int           quiet_cycles;
	bit           calm;

	imu_up_vector_complementary_filter i_dut (.*);

	imuf_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver stalls about 17% of cycles, none during the calm stretch
	always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 17);

	always @(posedge clk) begin
		if (s_tvalid && s_tready || m_tvalid && m_tready || cfg_valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// drop valid, then wait until every expected result has been taken
	task automatic drain;
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_axis(input int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(32'h4_0000) - 32'h2_0000;
			default: return $urandom_range(32'hA_0000) - 32'h5_0000;
		endcase
	endfunction

	task automatic send_sample(input logic [31:0] gx, gy, gz, ax, ay, az,
			input logic [23:0] dt);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {dt, az, ay, ax, gz, gy, gx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(input int count);
		int gm, am;
		for (int k = 0; k < count; k++) begin
			gm = ($urandom_range(9) == 0) ? 0 : 1;
			am = ($urandom_range(9) == 0) ? 0 : 2;
			send_sample(rand_axis(gm), rand_axis(gm), rand_axis(gm), rand_axis(am),
				rand_axis(am), rand_axis(am),
				($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40000)));
		end
	endtask

	initial begin
		quiet_cycles = 0;
		calm = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = CFG_FILTER_RATE;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, zero step, gravity in window, oversized values
		send_sample(0, 0, 0, 0, 0, 32'h9_CCCC, 24'd0);
		send_sample(0, 0, 0, 0, 0, 32'h9_CCCC, 24'hFF_FFFF);
		send_sample(32'h1_0000, 32'hFFFF_0000, 32'h8000, 32'h2_0000, 32'h3_0000,
			32'h9_0000, 24'd16777);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 24'h80_0000);
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8_0000, 0, 0, 24'd1);
		send_sample(0, 0, 32'h3_0000, 32'hFFF4_0000, 0, 0, 24'd5000);
		send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			32'h3333_3333, 32'hCCCC_CCCC, 24'hAA_AAAA);
		drain();
		// low bound zero, full filter rate
		write_reg(CFG_FILTER_RATE, 31'hFF_FFFF);
		write_reg(CFG_WINDOW_LOW, 31'd0);
		write_reg(CFG_WINDOW_HIGH, 31'h7FFF_FFFF);
		send_sample(0, 0, 0, 0, 0, 32'd1, 24'd1000);
		send_sample(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 24'hFF_FFFF);
		send_random(60);
		drain();
		// empty window
		write_reg(CFG_WINDOW_LOW, 31'h7FFF_FFFF);
		write_reg(CFG_WINDOW_HIGH, 31'd0);
		write_reg(CFG_FILTER_RATE, 31'd0);
		send_random(60);
		drain();
		write_reg(CFG_FILTER_RATE, 31'(FILTER_RATE_RESET));
		write_reg(CFG_WINDOW_LOW, WINDOW_LOW_RESET);
		write_reg(CFG_WINDOW_HIGH, WINDOW_HIGH_RESET);
		send_random(400);
		calm = 1;
		send_random(150);
		calm = 0;
		drain();
		write_reg(CFG_FILTER_RATE, 31'($urandom_range(32'h40_0000)));
		write_reg(CFG_WINDOW_LOW, 31'($urandom_range(32'h6_0000)));
		write_reg(CFG_WINDOW_HIGH, 31'($urandom_range(32'hC_0000, 32'h7FFF_FFFF)));
		send_random(360);
		drain();
		if (error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
